>>> src/rrp_pkg.sv
// Shared types and codes for the request parser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package rrp_pkg;

  localparam int LENGTH_TEXT_MAX = 32;
  localparam int LCHARS_W = $clog2(LENGTH_TEXT_MAX + 1);
  localparam int MAX_RESULTS = 4;

  localparam logic [31:0] CMD_LIMIT_RESET = 32'd1073741824;
  localparam logic [30:0] BULK_LIMIT_RESET = 31'd536870912;

  localparam logic [0:0] REG_CMD_LIMIT = 1'd0;
  localparam logic [0:0] REG_BULK_LIMIT = 1'd1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_INLINE, PH_ALEN, PH_ALEN_CR, PH_ARGSTART, PH_BLEN, PH_BLEN_CR,
    PH_BDATA, PH_BTERM_CR, PH_BTERM_LF, PH_LINE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE, KIND_ARG_END, KIND_CMD_END, KIND_ERROR
  } kind_t;

  localparam logic [3:0] ERR_NONE = 4'd0;
  localparam logic [3:0] ERR_ARRAY_LEN = 4'd1;
  localparam logic [3:0] ERR_BULK_LEN = 4'd2;
  localparam logic [3:0] ERR_BULK_BIG = 4'd3;
  localparam logic [3:0] ERR_ELEM_TYPE = 4'd4;
  localparam logic [3:0] ERR_LINE_TERM = 4'd5;
  localparam logic [3:0] ERR_BOOL = 4'd6;
  localparam logic [3:0] ERR_BULK_TERM = 4'd7;
  localparam logic [3:0] ERR_VERB_PREFIX = 4'd8;
  localparam logic [3:0] ERR_ESC_OPEN = 4'd9;
  localparam logic [3:0] ERR_HEX_ESC = 4'd10;
  localparam logic [3:0] ERR_QUOTE_OPEN = 4'd11;
  localparam logic [3:0] ERR_AFTER_QUOTE = 4'd12;
  localparam logic [3:0] ERR_CMD_LIMIT = 4'd13;

  localparam logic [2:0] ET_BULK = 3'd0;
  localparam logic [2:0] ET_VERBATIM = 3'd1;
  localparam logic [2:0] ET_SIMPLE = 3'd2;
  localparam logic [2:0] ET_INTEGER = 3'd3;
  localparam logic [2:0] ET_DOUBLE = 3'd4;
  localparam logic [2:0] ET_BIGNUM = 3'd5;
  localparam logic [2:0] ET_BOOL = 3'd6;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [3:0]  code;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [2:0]                cnt;
  } group_t;

endpackage

>>> src/rrp_parser.sv
// Parser state, configuration registers and per-byte decode.
// Produces the group of results for each accepted byte; uses rrp_pkg.
`timescale 1ns / 1ps
module rrp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output rrp_pkg::group_t       grp_next
);

  typedef struct packed {
    rrp_pkg::phase_t              phase;
    logic [63:0]                  accum;
    logic                         lf_sign;
    logic                         lf_over;
    logic                         lf_digit;
    logic                         lf_bad;
    logic [rrp_pkg::LCHARS_W-1:0] lchars;
    logic [30:0]                  args_left;
    logic [30:0]                  bulk_left;
    logic [31:0]                  used;
    logic [2:0]                   etype;
    logic [7:0]                   hold;
    logic [2:0]                   hcnt;
    logic                         qu;
    logic                         dq;
    logic                         esc;
    logic                         tok;
    logic                         cr;
    logic                         closed;
    logic                         any;
    logic                         hex;
    logic [3:0]                   fault;
    logic                         err;
  } state_t;

  typedef struct packed {
    state_t          st;
    rrp_pkg::group_t g;
  } work_t;

  localparam logic [7:0] C_CR = 8'h0D;
  localparam logic [7:0] C_LF = 8'h0A;
  localparam logic [67:0] INT64_TOP = 68'h7FFF_FFFF_FFFF_FFFF;

  state_t      st;
  state_t      st_next;
  logic [31:0] cmd_limit;
  logic [30:0] bulk_limit;

  function automatic work_t push(work_t w, rrp_pkg::kind_t k, logic [7:0] d, logic [3:0] e);
    work_t x;
    x = w;
    if (x.g.cnt < 3'(rrp_pkg::MAX_RESULTS)) begin
      x.g.res[x.g.cnt[1:0]].kind = k;
      x.g.res[x.g.cnt[1:0]].data = d;
      x.g.res[x.g.cnt[1:0]].code = e;
      x.g.cnt = x.g.cnt + 3'd1;
    end
    return x;
  endfunction

  // Drop everything emitted so far for this byte and latch the error.
  function automatic work_t raise(work_t w, logic [3:0] e);
    work_t x;
    x = w;
    x.g.cnt = 3'd0;
    x = push(x, rrp_pkg::KIND_ERROR, 8'd0, e);
    x.st.err = 1'b1;
    return x;
  endfunction

  function automatic work_t clear_cmd(work_t w);
    work_t x;
    x = w;
    x.st = '0;
    x.st.err = w.st.err;
    x.st.phase = rrp_pkg::PH_IDLE;
    return x;
  endfunction

  function automatic logic fits(work_t w, logic [1:0] n);
    return ({1'b0, w.st.used} + {31'd0, n}) <= {1'b0, cmd_limit};
  endfunction

  function automatic work_t finish_arg(work_t w);
    work_t x;
    x = push(w, rrp_pkg::KIND_ARG_END, 8'd0, rrp_pkg::ERR_NONE);
    if (x.st.args_left != 31'd0) x.st.args_left = x.st.args_left - 31'd1;
    if (x.st.args_left == 31'd0) begin
      x = push(x, rrp_pkg::KIND_CMD_END, 8'd0, rrp_pkg::ERR_NONE);
      x = clear_cmd(x);
    end else begin
      x.st.phase = rrp_pkg::PH_ARGSTART;
    end
    return x;
  endfunction

  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= "0" && c <= "9") v = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") v = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") v = {1'b1, 4'(c - "A" + 8'd10)};
    return v;
  endfunction

  function automatic work_t ichar(work_t w, logic [7:0] c);
    work_t      x;
    logic       blank;
    logic [4:0] hv;
    logic [7:0] m;
    logic [7:0] q;
    x = w;
    blank = (c == " ") || (c == 8'h09);
    hv = hex_val(c);
    m = c;
    q = x.st.dq ? 8'h22 : 8'h27;
    if (x.st.fault != 4'd0) begin
      x = w;
    end else if (x.st.hex) begin
      if (!hv[4]) begin
        x.st.fault = rrp_pkg::ERR_HEX_ESC;
      end else if (x.st.hcnt == 3'd0) begin
        x.st.hold = {4'd0, hv[3:0]};
        x.st.hcnt = 3'd1;
      end else begin
        x = push(x, rrp_pkg::KIND_BYTE, {x.st.hold[3:0], hv[3:0]}, rrp_pkg::ERR_NONE);
        x.st.hex = 1'b0;
        x.st.hcnt = 3'd0;
        x.st.hold = 8'd0;
      end
    end else if (x.st.esc) begin
      x.st.esc = 1'b0;
      if (c == "x") begin
        x.st.hex = 1'b1;
        x.st.hcnt = 3'd0;
        x.st.hold = 8'd0;
      end else begin
        case (c)
          "n":     m = 8'd10;
          "r":     m = 8'd13;
          "t":     m = 8'd9;
          "b":     m = 8'd8;
          "a":     m = 8'd7;
          default: m = c;
        endcase
        x = push(x, rrp_pkg::KIND_BYTE, m, rrp_pkg::ERR_NONE);
      end
    end else if (x.st.closed) begin
      x.st.closed = 1'b0;
      if (!blank) x.st.fault = rrp_pkg::ERR_AFTER_QUOTE;
    end else if (x.st.qu) begin
      if (c == q) begin
        x = push(x, rrp_pkg::KIND_ARG_END, 8'd0, rrp_pkg::ERR_NONE);
        x.st.qu = 1'b0;
        x.st.dq = 1'b0;
        x.st.any = 1'b1;
        x.st.closed = 1'b1;
      end else if (c == 8'h5C) begin
        x.st.esc = 1'b1;
      end else begin
        x = push(x, rrp_pkg::KIND_BYTE, c, rrp_pkg::ERR_NONE);
      end
    end else if (!x.st.tok && blank) begin
      x = w;
    end else if (!x.st.tok && (c == 8'h27 || c == 8'h22)) begin
      x.st.qu = 1'b1;
      x.st.dq = (c == 8'h22);
    end else begin
      x.st.tok = 1'b1;
      if (blank) begin
        x = push(x, rrp_pkg::KIND_ARG_END, 8'd0, rrp_pkg::ERR_NONE);
        x.st.tok = 1'b0;
        x.st.any = 1'b1;
      end else if (c == 8'h5C) begin
        x.st.esc = 1'b1;
      end else begin
        x = push(x, rrp_pkg::KIND_BYTE, c, rrp_pkg::ERR_NONE);
      end
    end
    return x;
  endfunction

  function automatic work_t inline_byte(work_t w, logic [7:0] c);
    work_t x;
    x = w;
    if (!fits(x, 2'd1)) begin
      x = raise(x, rrp_pkg::ERR_CMD_LIMIT);
    end else begin
      x.st.used = x.st.used + 32'd1;
      if (c == C_LF) begin
        if (x.st.fault != 4'd0) x = raise(x, x.st.fault);
        else if (x.st.hex) x = raise(x, rrp_pkg::ERR_HEX_ESC);
        else if (x.st.esc) x = raise(x, rrp_pkg::ERR_ESC_OPEN);
        else if (x.st.qu) x = raise(x, rrp_pkg::ERR_QUOTE_OPEN);
        else begin
          if (x.st.tok) begin
            x = push(x, rrp_pkg::KIND_ARG_END, 8'd0, rrp_pkg::ERR_NONE);
            x.st.any = 1'b1;
          end
          if (x.st.any) x = push(x, rrp_pkg::KIND_CMD_END, 8'd0, rrp_pkg::ERR_NONE);
          x = clear_cmd(x);
        end
      end else begin
        if (x.st.cr) begin
          x.st.cr = 1'b0;
          x = ichar(x, C_CR);
        end
        if (c == C_CR) x.st.cr = 1'b1;
        else x = ichar(x, c);
      end
    end
    return x;
  endfunction

  function automatic work_t line_content(work_t w, logic [7:0] c);
    work_t x;
    x = w;
    if (x.st.etype == rrp_pkg::ET_BOOL) begin
      if (x.st.hcnt == 3'd0) x.st.hold = c;
      if (x.st.hcnt < 3'd2) x.st.hcnt = x.st.hcnt + 3'd1;
    end else begin
      x = push(x, rrp_pkg::KIND_BYTE, c, rrp_pkg::ERR_NONE);
    end
    return x;
  endfunction

  function automatic work_t line_byte(work_t w, logic [7:0] c);
    work_t x;
    x = w;
    if (!fits(x, 2'd1)) begin
      x = raise(x, rrp_pkg::ERR_CMD_LIMIT);
    end else begin
      x.st.used = x.st.used + 32'd1;
      if (c == C_LF) begin
        if (!x.st.cr) begin
          x = raise(x, rrp_pkg::ERR_LINE_TERM);
        end else begin
          x.st.cr = 1'b0;
          if (x.st.etype != rrp_pkg::ET_BOOL) begin
            x = finish_arg(x);
          end else if (x.st.hcnt == 3'd1 && x.st.hold == "t") begin
            x = finish_arg(push(x, rrp_pkg::KIND_BYTE, "1", rrp_pkg::ERR_NONE));
          end else if (x.st.hcnt == 3'd1 && x.st.hold == "f") begin
            x = finish_arg(push(x, rrp_pkg::KIND_BYTE, "0", rrp_pkg::ERR_NONE));
          end else begin
            x = raise(x, rrp_pkg::ERR_BOOL);
          end
        end
      end else begin
        if (x.st.cr) begin
          x.st.cr = 1'b0;
          x = line_content(x, C_CR);
        end
        if (c == C_CR) x.st.cr = 1'b1;
        else x = line_content(x, c);
      end
    end
    return x;
  endfunction

  function automatic work_t length_byte(work_t w, logic [7:0] c, logic arr);
    work_t       x;
    logic [3:0]  e;
    logic [67:0] prod;
    x = w;
    e = arr ? rrp_pkg::ERR_ARRAY_LEN : rrp_pkg::ERR_BULK_LEN;
    prod = ({4'd0, x.st.accum} << 3) + ({4'd0, x.st.accum} << 1) + {60'd0, c - "0"};
    if (c == C_CR) begin
      x.st.phase = arr ? rrp_pkg::PH_ALEN_CR : rrp_pkg::PH_BLEN_CR;
    end else if (c == C_LF || x.st.lchars >= rrp_pkg::LCHARS_W'(rrp_pkg::LENGTH_TEXT_MAX)) begin
      x = raise(x, e);
    end else begin
      if (c >= "0" && c <= "9") begin
        x.st.lf_digit = 1'b1;
        if (!x.st.lf_over) begin
          if (prod > INT64_TOP) x.st.lf_over = 1'b1;
          else x.st.accum = prod[63:0];
        end
      end else if (c == "-" && x.st.lchars == '0) begin
        x.st.lf_sign = 1'b1;
      end else begin
        x.st.lf_bad = 1'b1;
      end
      x.st.lchars = x.st.lchars + 1'b1;
      if (!fits(x, 2'd1)) x = raise(x, rrp_pkg::ERR_CMD_LIMIT);
      else x.st.used = x.st.used + 32'd1;
    end
    return x;
  endfunction

  function automatic work_t length_close(work_t w, logic [7:0] c, logic arr);
    work_t      x;
    logic [3:0] e;
    logic       bad;
    x = w;
    e = arr ? rrp_pkg::ERR_ARRAY_LEN : rrp_pkg::ERR_BULK_LEN;
    bad = x.st.lchars == '0 || x.st.lf_bad || !x.st.lf_digit || x.st.lf_over ||
          (x.st.lf_sign && x.st.accum != 64'd0);
    if (c != C_LF) begin
      x = raise(x, e);
    end else if (!fits(x, 2'd2)) begin
      x = raise(x, rrp_pkg::ERR_CMD_LIMIT);
    end else if (bad) begin
      x = raise(x, e);
    end else if (arr) begin
      x.st.used = x.st.used + 32'd2;
      if (x.st.accum[63:31] != 33'd0) begin
        x = raise(x, rrp_pkg::ERR_ARRAY_LEN);
      end else if (x.st.accum == 64'd0) begin
        x = clear_cmd(x);
      end else begin
        x.st.args_left = x.st.accum[30:0];
        x.st.phase = rrp_pkg::PH_ARGSTART;
      end
    end else begin
      x.st.used = x.st.used + 32'd2;
      if (x.st.accum > {33'd0, bulk_limit}) begin
        x = raise(x, rrp_pkg::ERR_BULK_BIG);
      end else begin
        x.st.bulk_left = x.st.accum[30:0];
        x.st.hcnt = 3'd0;
        x.st.hold = 8'd0;
        x.st.phase = (x.st.accum[30:0] != 31'd0) ? rrp_pkg::PH_BDATA : rrp_pkg::PH_BTERM_CR;
      end
    end
    return x;
  endfunction

  function automatic work_t start_length(work_t w, rrp_pkg::phase_t ph);
    work_t x;
    x = w;
    x.st.accum = 64'd0;
    x.st.lf_sign = 1'b0;
    x.st.lf_over = 1'b0;
    x.st.lf_digit = 1'b0;
    x.st.lf_bad = 1'b0;
    x.st.lchars = '0;
    x.st.phase = ph;
    return x;
  endfunction

  function automatic work_t arg_start(work_t w, logic [7:0] c);
    work_t      x;
    logic [2:0] t;
    logic       ok;
    x = w;
    ok = 1'b1;
    t = rrp_pkg::ET_BULK;
    case (c)
      "$":     t = rrp_pkg::ET_BULK;
      "=":     t = rrp_pkg::ET_VERBATIM;
      "+":     t = rrp_pkg::ET_SIMPLE;
      ":":     t = rrp_pkg::ET_INTEGER;
      ",":     t = rrp_pkg::ET_DOUBLE;
      "(":     t = rrp_pkg::ET_BIGNUM;
      "#":     t = rrp_pkg::ET_BOOL;
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      x = raise(x, rrp_pkg::ERR_ELEM_TYPE);
    end else if (!fits(x, 2'd1)) begin
      x = raise(x, rrp_pkg::ERR_CMD_LIMIT);
    end else begin
      x.st.used = x.st.used + 32'd1;
      x.st.etype = t;
      x.st.hcnt = 3'd0;
      x.st.hold = 8'd0;
      {x.st.qu, x.st.dq, x.st.esc, x.st.tok, x.st.cr, x.st.closed, x.st.any, x.st.hex} = '0;
      if (t == rrp_pkg::ET_BULK || t == rrp_pkg::ET_VERBATIM)
        x = start_length(x, rrp_pkg::PH_BLEN);
      else x.st.phase = rrp_pkg::PH_LINE;
    end
    return x;
  endfunction

  function automatic work_t bulk_byte(work_t w, logic [7:0] c);
    work_t x;
    x = w;
    if (!fits(x, 2'd1)) begin
      x = raise(x, rrp_pkg::ERR_CMD_LIMIT);
    end else begin
      x.st.used = x.st.used + 32'd1;
      // verbatim: drop the four-byte format prefix, remember if its colon is right
      if (x.st.etype == rrp_pkg::ET_VERBATIM && x.st.hcnt < 3'd4) begin
        if (x.st.hcnt == 3'd3) x.st.hold = {7'd0, c == ":"};
        x.st.hcnt = x.st.hcnt + 3'd1;
      end else begin
        x = push(x, rrp_pkg::KIND_BYTE, c, rrp_pkg::ERR_NONE);
      end
      if (x.st.bulk_left != 31'd0) x.st.bulk_left = x.st.bulk_left - 31'd1;
      if (x.st.bulk_left == 31'd0) x.st.phase = rrp_pkg::PH_BTERM_CR;
    end
    return x;
  endfunction

  always_comb begin
    work_t w;
    w.st = st;
    w.g = '0;
    if (!st.err) begin
      case (st.phase)
        rrp_pkg::PH_IDLE: begin
          if (rx_byte == C_CR || rx_byte == C_LF) begin
            w.st = st;
          end else if (rx_byte == "*") begin
            w.st.used = 32'd1;
            w = start_length(w, rrp_pkg::PH_ALEN);
          end else begin
            w = clear_cmd(w);
            w.st.phase = rrp_pkg::PH_INLINE;
            w = inline_byte(w, rx_byte);
          end
        end
        rrp_pkg::PH_INLINE:   w = inline_byte(w, rx_byte);
        rrp_pkg::PH_ALEN:     w = length_byte(w, rx_byte, 1'b1);
        rrp_pkg::PH_ALEN_CR:  w = length_close(w, rx_byte, 1'b1);
        rrp_pkg::PH_ARGSTART: w = arg_start(w, rx_byte);
        rrp_pkg::PH_BLEN:     w = length_byte(w, rx_byte, 1'b0);
        rrp_pkg::PH_BLEN_CR:  w = length_close(w, rx_byte, 1'b0);
        rrp_pkg::PH_BDATA:    w = bulk_byte(w, rx_byte);
        rrp_pkg::PH_BTERM_CR: begin
          if (rx_byte != C_CR) w = raise(w, rrp_pkg::ERR_BULK_TERM);
          else if (!fits(w, 2'd1)) w = raise(w, rrp_pkg::ERR_CMD_LIMIT);
          else begin
            w.st.used = w.st.used + 32'd1;
            w.st.phase = rrp_pkg::PH_BTERM_LF;
          end
        end
        rrp_pkg::PH_BTERM_LF: begin
          if (rx_byte != C_LF) w = raise(w, rrp_pkg::ERR_BULK_TERM);
          else if (!fits(w, 2'd1)) w = raise(w, rrp_pkg::ERR_CMD_LIMIT);
          else if (w.st.etype == rrp_pkg::ET_VERBATIM &&
                   !(w.st.hcnt == 3'd4 && w.st.hold == 8'd1))
            w = raise(w, rrp_pkg::ERR_VERB_PREFIX);
          else begin
            w.st.used = w.st.used + 32'd1;
            w = finish_arg(w);
          end
        end
        rrp_pkg::PH_LINE:     w = line_byte(w, rx_byte);
        default:              w = clear_cmd(w);
      endcase
    end
    st_next = w.st;
    grp_next = w.g;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_limit <= rrp_pkg::CMD_LIMIT_RESET;
      bulk_limit <= rrp_pkg::BULK_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rrp_pkg::REG_CMD_LIMIT:  cmd_limit <= cfg_data;
        rrp_pkg::REG_BULK_LIMIT: bulk_limit <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/rrp_out_queue.sv
// Result register: holds one byte's group of results and hands them out one per item.
// Uses rrp_pkg for the result group type.
`timescale 1ns / 1ps
module rrp_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  rrp_pkg::group_t grp_in,
  input  logic            out_stall,
  output logic            out_valid,
  output logic            in_stall,
  output rrp_pkg::result_t res
);

  rrp_pkg::group_t grp;
  logic [2:0]      idx;
  logic            taken;
  logic            last;

  assign out_valid = idx != grp.cnt;
  assign taken = out_valid && !out_stall;
  assign last = taken && (idx + 3'd1 == grp.cnt);
  // take a new byte once the final result of the current group leaves
  assign in_stall = out_valid && !last;
  assign res = grp.res[idx[1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      grp.cnt <= 3'd0;
      idx <= 3'd0;
    end else if (load) begin
      grp <= grp_in;
      idx <= 3'd0;
    end else if (taken) begin
      idx <= idx + 3'd1;
    end
  end

endmodule

>>> src/resp_request_parser.sv
// Top level of the streaming request parser: byte channel in, result channel out.
// Instantiates rrp_parser and rrp_out_queue; uses rrp_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   input    | in_valid / in_stall    | rx_byte
//   output   | out_valid / out_stall  | kind, data_byte, error_code
//   config   | cfg_we, cfg_index      | cfg_data
//
// Each byte is decoded in the cycle it is accepted; its results appear from the next cycle.
// A byte with zero or one result lets a new byte in every cycle while out_stall is low; a byte
// with more results holds the input while the result register drains them one per cycle when out_stall is low.
// Input is taken in the same cycle the last pending result leaves.
// Synchronous reset restores both limits and the idle parse state.
`timescale 1ns / 1ps
module resp_request_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [3:0]  error_code,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rrp_pkg::group_t  grp_next;
  rrp_pkg::result_t res;
  logic             accept;

  assign accept = in_valid && !in_stall;

  rrp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .grp_next  (grp_next)
  );

  rrp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .grp_in    (grp_next),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .in_stall  (in_stall),
    .res       (res)
  );

  assign kind = res.kind;
  assign data_byte = res.data;
  assign error_code = res.code;

endmodule

>>> src/rrp_checker.sv
// Port-level checks for the request parser, bound to the top level.
// Uses rrp_pkg for result kinds.
`timescale 1ns / 1ps
module rrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] data_byte,
  input logic [3:0] error_code
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte))
    else $error("stalled result changed");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != rrp_pkg::KIND_BYTE |-> data_byte == 8'd0)
    else $error("data on a non-byte result");

  a_code_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == rrp_pkg::KIND_ERROR) == (error_code != 4'd0)))
    else $error("error code does not match kind");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && kind == rrp_pkg::KIND_ERROR |=> !out_valid)
    else $error("result after an error");

endmodule

bind resp_request_parser rrp_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .data_byte  (data_byte),
  .error_code (error_code)
);

>>> tb/tb_resp_request_parser.sv
// Testbench for resp_request_parser: drives request bytes and checks every result item.
// Holds its own parser model and a queue of expected results; depends on rrp_pkg.
`timescale 1ns / 1ps
module tb_resp_request_parser;

  localparam int LEN_MAX = 32;
  localparam logic [63:0] I64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] LF_SIGN = 8'h01, LF_OVER = 8'h02, LF_DIGIT = 8'h04, LF_BAD = 8'h08;
  localparam logic [7:0] IL_QUOTED = 8'h01, IL_DQ = 8'h02, IL_ESC = 8'h04, IL_TOKEN = 8'h08;
  localparam logic [7:0] IL_CR = 8'h10, IL_CLOSED = 8'h20, IL_ANY = 8'h40, IL_HEX = 8'h80;

  class parser_scoreboard;
    logic [31:0]      cmd_limit;
    logic [30:0]      bulk_limit;
    rrp_pkg::phase_t  phase;
    logic [63:0]      len_acc;
    logic [7:0]       len_flags;
    int               len_chars;
    logic [31:0]      args_left, bulk_left, cmd_used;
    logic [2:0]       etype;
    logic [15:0]      hold;
    int               hold_cnt;
    logic [7:0]       il_flags;
    logic [3:0]       il_fault;
    bit               latched;
    rrp_pkg::result_t step_res[$];
    rrp_pkg::result_t pending[$];
    int               errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void clear_cmd();
      phase = rrp_pkg::PH_IDLE; len_acc = 0; len_flags = 0; len_chars = 0;
      args_left = 0; bulk_left = 0; cmd_used = 0; etype = 0; hold = 0; hold_cnt = 0;
      il_flags = 0; il_fault = 0;
    endfunction

    function void restart();
      cmd_limit = rrp_pkg::CMD_LIMIT_RESET;
      bulk_limit = rrp_pkg::BULK_LIMIT_RESET;
      clear_cmd();
      latched = 0;
      pending.delete();
    endfunction

    function void set_reg(logic [0:0] idx, logic [31:0] v);
      if (idx == rrp_pkg::REG_CMD_LIMIT) cmd_limit = v;
      else bulk_limit = v[30:0];
    endfunction

    function void push(rrp_pkg::kind_t k, logic [7:0] d, logic [3:0] c);
      rrp_pkg::result_t r;
      r.kind = k; r.data = d; r.code = c;
      if (step_res.size() < rrp_pkg::MAX_RESULTS) step_res.insert(step_res.size(), r);
    endfunction

    function void fail(logic [3:0] c);
      step_res.delete();
      push(rrp_pkg::KIND_ERROR, 8'd0, c);
      latched = 1;
    endfunction

    function bit charge(int n);
      if ({32'd0, cmd_used} + n > {32'd0, cmd_limit}) return 0;
      cmd_used += n;
      return 1;
    endfunction

    function void start_len(rrp_pkg::phase_t p);
      len_acc = 0; len_flags = 0; len_chars = 0; phase = p;
    endfunction

    function void end_arg();
      push(rrp_pkg::KIND_ARG_END, 8'd0, rrp_pkg::ERR_NONE);
      if (args_left > 0) args_left--;
      if (args_left == 0) begin
        push(rrp_pkg::KIND_CMD_END, 8'd0, rrp_pkg::ERR_NONE);
        clear_cmd();
      end else phase = rrp_pkg::PH_ARGSTART;
    endfunction

    function void len_byte(logic [7:0] c, bit arr);
      logic [3:0] code;
      logic [63:0] d;
      code = arr ? rrp_pkg::ERR_ARRAY_LEN : rrp_pkg::ERR_BULK_LEN;
      if (c == 8'h0D) begin
        phase = arr ? rrp_pkg::PH_ALEN_CR : rrp_pkg::PH_BLEN_CR;
        return;
      end
      if (c == 8'h0A || len_chars >= LEN_MAX) begin
        fail(code);
        return;
      end
      if (c >= "0" && c <= "9") begin
        d = c - "0";
        len_flags |= LF_DIGIT;
        if (!(len_flags & LF_OVER)) begin
          if (len_acc > (I64_TOP - d) / 10) len_flags |= LF_OVER;
          else len_acc = len_acc * 10 + d;
        end
      end else if (c == "-" && len_chars == 0) len_flags |= LF_SIGN;
      else len_flags |= LF_BAD;
      len_chars++;
      if (!charge(1)) fail(rrp_pkg::ERR_CMD_LIMIT);
    endfunction

    function void len_close(logic [7:0] c, bit arr);
      logic [3:0] code;
      bit bad;
      code = arr ? rrp_pkg::ERR_ARRAY_LEN : rrp_pkg::ERR_BULK_LEN;
      if (c != 8'h0A) begin
        fail(code);
        return;
      end
      if (!charge(2)) begin
        fail(rrp_pkg::ERR_CMD_LIMIT);
        return;
      end
      bad = len_chars == 0 || (len_flags & LF_BAD) || !(len_flags & LF_DIGIT) ||
            (len_flags & LF_OVER) || ((len_flags & LF_SIGN) && len_acc != 0);
      if (bad) begin
        fail(code);
        return;
      end
      if (arr) begin
        if (len_acc > 64'h7FFF_FFFF) fail(rrp_pkg::ERR_ARRAY_LEN);
        else if (len_acc == 0) clear_cmd();
        else begin
          args_left = len_acc[31:0];
          phase = rrp_pkg::PH_ARGSTART;
        end
      end else begin
        if (len_acc > {33'd0, bulk_limit}) fail(rrp_pkg::ERR_BULK_BIG);
        else begin
          bulk_left = len_acc[31:0];
          hold_cnt = 0; hold = 0;
          phase = bulk_left != 0 ? rrp_pkg::PH_BDATA : rrp_pkg::PH_BTERM_CR;
        end
      end
    endfunction

    function int hexval(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void il_char(logic [7:0] c);
      bit blank;
      int v;
      logic [7:0] q;
      blank = c == " " || c == 8'h09;
      if (il_fault != 0) return;
      if (il_flags & IL_HEX) begin
        v = hexval(c);
        if (v < 0) begin
          il_fault = rrp_pkg::ERR_HEX_ESC;
          return;
        end
        if (hold_cnt == 0) begin
          hold = 16'(v); hold_cnt = 1;
          return;
        end
        push(rrp_pkg::KIND_BYTE, {hold[3:0], 4'(v)}, rrp_pkg::ERR_NONE);
        il_flags &= ~IL_HEX; hold_cnt = 0; hold = 0;
        return;
      end
      if (il_flags & IL_ESC) begin
        il_flags &= ~IL_ESC;
        case (c)
          "x": begin
            il_flags |= IL_HEX; hold_cnt = 0; hold = 0;
            return;
          end
          "n": c = 8'd10;
          "r": c = 8'd13;
          "t": c = 8'd9;
          "b": c = 8'd8;
          "a": c = 8'd7;
          default: ;
        endcase
        push(rrp_pkg::KIND_BYTE, c, rrp_pkg::ERR_NONE);
        return;
      end
      if (il_flags & IL_CLOSED) begin
        il_flags &= ~IL_CLOSED;
        if (!blank) il_fault = rrp_pkg::ERR_AFTER_QUOTE;
        return;
      end
      if (il_flags & IL_QUOTED) begin
        q = (il_flags & IL_DQ) ? 8'h22 : 8'h27;
        if (c == q) begin
          push(rrp_pkg::KIND_ARG_END, 8'd0, rrp_pkg::ERR_NONE);
          il_flags = (il_flags & ~(IL_QUOTED | IL_DQ)) | IL_ANY | IL_CLOSED;
        end else if (c == "\\") il_flags |= IL_ESC;
        else push(rrp_pkg::KIND_BYTE, c, rrp_pkg::ERR_NONE);
        return;
      end
      if (!(il_flags & IL_TOKEN)) begin
        if (blank) return;
        if (c == 8'h27 || c == 8'h22) begin
          il_flags |= IL_QUOTED;
          if (c == 8'h22) il_flags |= IL_DQ;
          return;
        end
        il_flags |= IL_TOKEN;
      end
      if (blank) begin
        push(rrp_pkg::KIND_ARG_END, 8'd0, rrp_pkg::ERR_NONE);
        il_flags = (il_flags & ~IL_TOKEN) | IL_ANY;
      end else if (c == "\\") il_flags |= IL_ESC;
      else push(rrp_pkg::KIND_BYTE, c, rrp_pkg::ERR_NONE);
    endfunction

    function void il_byte(logic [7:0] c);
      if (!charge(1)) begin
        fail(rrp_pkg::ERR_CMD_LIMIT);
        return;
      end
      if (c == 8'h0A) begin
        if (il_fault != 0) fail(il_fault);
        else if (il_flags & IL_HEX) fail(rrp_pkg::ERR_HEX_ESC);
        else if (il_flags & IL_ESC) fail(rrp_pkg::ERR_ESC_OPEN);
        else if (il_flags & IL_QUOTED) fail(rrp_pkg::ERR_QUOTE_OPEN);
        else begin
          if (il_flags & IL_TOKEN) begin
            push(rrp_pkg::KIND_ARG_END, 8'd0, rrp_pkg::ERR_NONE);
            il_flags |= IL_ANY;
          end
          if (il_flags & IL_ANY) push(rrp_pkg::KIND_CMD_END, 8'd0, rrp_pkg::ERR_NONE);
          clear_cmd();
        end
        return;
      end
      if (il_flags & IL_CR) begin
        il_flags &= ~IL_CR;
        il_char(8'h0D);
      end
      if (c == 8'h0D) il_flags |= IL_CR;
      else il_char(c);
    endfunction

    function void line_content(logic [7:0] c);
      if (etype == rrp_pkg::ET_BOOL) begin
        if (hold_cnt == 0) hold = c;
        if (hold_cnt < 2) hold_cnt++;
      end else push(rrp_pkg::KIND_BYTE, c, rrp_pkg::ERR_NONE);
    endfunction

    function void line_byte(logic [7:0] c);
      if (!charge(1)) begin
        fail(rrp_pkg::ERR_CMD_LIMIT);
        return;
      end
      if (c == 8'h0A) begin
        if (!(il_flags & IL_CR)) begin
          fail(rrp_pkg::ERR_LINE_TERM);
          return;
        end
        il_flags &= ~IL_CR;
        if (etype == rrp_pkg::ET_BOOL) begin
          if (hold_cnt == 1 && hold == "t") push(rrp_pkg::KIND_BYTE, "1", rrp_pkg::ERR_NONE);
          else if (hold_cnt == 1 && hold == "f")
            push(rrp_pkg::KIND_BYTE, "0", rrp_pkg::ERR_NONE);
          else begin
            fail(rrp_pkg::ERR_BOOL);
            return;
          end
        end
        end_arg();
        return;
      end
      if (il_flags & IL_CR) begin
        il_flags &= ~IL_CR;
        line_content(8'h0D);
      end
      if (c == 8'h0D) il_flags |= IL_CR;
      else line_content(c);
    endfunction

    function void arg_start(logic [7:0] c);
      logic [2:0] t;
      case (c)
        "$": t = rrp_pkg::ET_BULK;
        "=": t = rrp_pkg::ET_VERBATIM;
        "+": t = rrp_pkg::ET_SIMPLE;
        ":": t = rrp_pkg::ET_INTEGER;
        ",": t = rrp_pkg::ET_DOUBLE;
        "(": t = rrp_pkg::ET_BIGNUM;
        "#": t = rrp_pkg::ET_BOOL;
        default: begin
          fail(rrp_pkg::ERR_ELEM_TYPE);
          return;
        end
      endcase
      if (!charge(1)) begin
        fail(rrp_pkg::ERR_CMD_LIMIT);
        return;
      end
      etype = t; hold_cnt = 0; hold = 0; il_flags = 0;
      if (t == rrp_pkg::ET_BULK || t == rrp_pkg::ET_VERBATIM) start_len(rrp_pkg::PH_BLEN);
      else phase = rrp_pkg::PH_LINE;
    endfunction

    function void bulk_byte(logic [7:0] c);
      if (!charge(1)) begin
        fail(rrp_pkg::ERR_CMD_LIMIT);
        return;
      end
      if (etype == rrp_pkg::ET_VERBATIM && hold_cnt < 4) begin
        if (hold_cnt == 3) hold = (c == ":");
        hold_cnt++;
      end else push(rrp_pkg::KIND_BYTE, c, rrp_pkg::ERR_NONE);
      if (bulk_left > 0) bulk_left--;
      if (bulk_left == 0) phase = rrp_pkg::PH_BTERM_CR;
    endfunction

    // Note one accepted byte and queue what it should produce.
    function void note_byte(logic [7:0] c);
      step_res.delete();
      if (!latched) begin
        case (phase)
          rrp_pkg::PH_IDLE: begin
            if (c == "*") begin
              cmd_used = 1;
              start_len(rrp_pkg::PH_ALEN);
            end else if (c != 8'h0D && c != 8'h0A) begin
              cmd_used = 0; il_flags = 0; il_fault = 0; hold_cnt = 0; hold = 0;
              phase = rrp_pkg::PH_INLINE;
              il_byte(c);
            end
          end
          rrp_pkg::PH_INLINE:   il_byte(c);
          rrp_pkg::PH_ALEN:     len_byte(c, 1);
          rrp_pkg::PH_ALEN_CR:  len_close(c, 1);
          rrp_pkg::PH_ARGSTART: arg_start(c);
          rrp_pkg::PH_BLEN:     len_byte(c, 0);
          rrp_pkg::PH_BLEN_CR:  len_close(c, 0);
          rrp_pkg::PH_BDATA:    bulk_byte(c);
          rrp_pkg::PH_BTERM_CR: begin
            if (c != 8'h0D) fail(rrp_pkg::ERR_BULK_TERM);
            else if (!charge(1)) fail(rrp_pkg::ERR_CMD_LIMIT);
            else phase = rrp_pkg::PH_BTERM_LF;
          end
          rrp_pkg::PH_BTERM_LF: begin
            if (c != 8'h0A) fail(rrp_pkg::ERR_BULK_TERM);
            else if (!charge(1)) fail(rrp_pkg::ERR_CMD_LIMIT);
            else if (etype == rrp_pkg::ET_VERBATIM && !(hold_cnt == 4 && hold == 1))
              fail(rrp_pkg::ERR_VERB_PREFIX);
            else end_arg();
          end
          rrp_pkg::PH_LINE: line_byte(c);
          default: clear_cmd();
        endcase
      end
      foreach (step_res[i]) pending.insert(pending.size(), step_res[i]);
    endfunction

    function void check_result(logic [1:0] k, logic [7:0] d, logic [3:0] c);
      rrp_pkg::result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind=%0d data=%h code=%0d", k, d, c);
        return;
      end
      e = pending.pop_front();
      if (e.kind != k || e.data != d || e.code != c) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp kind=%0d data=%h code=%0d, got kind=%0d data=%h code=%0d",
                   e.kind, e.data, e.code, k, d, c);
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_stall;
  logic [7:0]  rx_byte = 0;
  logic        out_valid, out_stall = 0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [3:0]  error_code;
  logic        cfg_we = 0;
  logic [0:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;

  parser_scoreboard sb = new();
  byte unsigned     stream[$];
  int               hold_off = 0;
  bit               bursty = 1;
  int               sent = 0;

  resp_request_parser DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_byte(rx_byte);
    if (!rst && out_valid && !out_stall) sb.check_result(kind, data_byte, error_code);
  end

  // Receiver stall pattern, with one long hold-off set by the test.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else if (sent % 97 < 30) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  task automatic add_byte(byte unsigned b);
    stream.insert(stream.size(), b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_bulk(int n);
    add_text($sformatf("$%0d\015\n", n));
    repeat (n) add_byte(8'($urandom_range(0, 255)));
    add_text("\015\n");
  endtask

  // Send one byte; valid stays high across back-to-back bytes.
  task automatic send_byte(byte unsigned b);
    in_valid <= 1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_stream();
    int burst;
    burst = 0;
    while (stream.size() > 0) begin
      if (bursty && burst == 0) begin
        in_valid <= 0;
        rx_byte <= 8'($urandom);
        repeat ($urandom_range(1, 4)) @(posedge clk);
        burst = $urandom_range(1, 12);
      end
      send_byte(stream.pop_front());
      if (burst > 0) burst--;
    end
    in_valid <= 0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(posedge clk);
    while (sb.pending.size() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // The block is reset only once, at the start, so each phase writes
  // config only after draining; the directed error is sent in the last phase.
  task automatic write_reg(logic [0:0] idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic add_random_cmd();
    int n, k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        n = $urandom_range(1, 4);
        add_text($sformatf("*%0d\015\n", n));
        repeat (n) begin
          case ($urandom_range(0, 7))
            0, 1, 2: add_bulk($urandom_range(0, 6));
            3: begin
              k = $urandom_range(0, 4);
              add_text($sformatf("=%0d\015\ntxt:", k + 4));
              repeat (k) add_byte(8'($urandom_range(0, 255)));
              add_text("\015\n");
            end
            4: add_text($urandom_range(0, 1) ? "#t\015\n" : "#f\015\n");
            5: add_text($sformatf(":%0d\015\n", $urandom));
            6: add_text("+OK\015x\015\n");
            default: add_text($sformatf(",%0d.5\015\n", $urandom_range(0, 99)));
          endcase
        end
      end
      4, 5, 6: begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: add_text("\"a\\x4Fb\\n\" ");
            1: add_text("'q\\t' ");
            2: add_text("\\z\t");
            default: begin
              repeat ($urandom_range(1, 5))
                add_byte(($urandom_range(8'h21, 8'h7E) == 8'h5C)
                         ? "k" : 8'($urandom_range(8'h41, 8'h5A)));
              add_text(" ");
            end
          endcase
        end
        if ($urandom_range(0, 1) != 0) add_text("\015\n");
        else add_text("\n");
      end
      7: add_text("\015\n\n*0\015\n*-0\015\n");
      8: begin
        add_byte(8'($urandom_range(8'h80, 8'hFF)));
        add_byte(8'($urandom_range(0, 8'h7F)) | 8'h01);
        add_text("\n");
      end
      default: add_text("*1\015\n$1\015\n\377\015\n");
    endcase
  endtask

  initial begin
    string errs[$];
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every element type, escapes, quotes, length edge cases.
    add_text("\015\n*3\015\n$3\015\nSET\015\n=7\015\ntxt:abc\015\n#t\015\n");
    add_text("*5\015\n+a\015b\015\n:-12\015\n,1.5\015\n(123\015\n#f\015\n");
    add_text("*-0\015\n*0\015\n*1\015\n$0\015\n\015\n");
    add_text("set \"k\\x41\\xfe\" 'v\\r\\b\\a\\q' \tx\015\n   \n");
    add_text("*1\015\n$-0\015\n\015\n*1\015\n$000\015\n\015\n");
    add_byte(8'h00); add_byte(8'hFF); add_text("\n");
    send_stream();
    drain();

    // Limits at their extremes, then a long receiver hold-off with full input.
    write_reg(rrp_pkg::REG_CMD_LIMIT, 32'hFFFF_FFFF);
    write_reg(rrp_pkg::REG_BULK_LIMIT, 32'h7FFF_FFFF);
    repeat (6) add_random_cmd();
    hold_off = 80;
    bursty = 0;
    send_stream();
    bursty = 1;
    drain();
    write_reg(rrp_pkg::REG_CMD_LIMIT, 32'd40);
    write_reg(rrp_pkg::REG_BULK_LIMIT, 32'd5);
    while (sent < 330) begin
      add_random_cmd();
      send_stream();
    end
    drain();

    // Each error latches until reset, so only one error ends the run; pick one at random.
    errs = '{"*1\015\n$6\015\n", "*x\015\n", "*1\015\n!", "*1\015\n+a\n", "*1\015\n#x\015\n",
             "*1\015\n$1\015\nab", "*1\015\n=5\015\nab;cd\015\n", "a\\\n", "a\\xg1\n",
             "'ab\n", "'a'b\n", "*99999999999\015\n", "*1\015\n$99999999999999999999\015\n",
             "*1\015\n$-1\015\n", "*\015\n", "*1\015x", "*\n",
             "*111111111111111111111111111111111\015\n",
             "aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa\n"};
    write_reg(rrp_pkg::REG_CMD_LIMIT, $urandom_range(0, 1) ? 32'd0 : 32'd12);
    write_reg(rrp_pkg::REG_BULK_LIMIT, 32'd0);
    add_text(errs[$urandom_range(0, errs.size() - 1)]);
    add_text("*1\015\n$1\015\nz\015\n");
    send_stream();
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_resp_request_parser: done, clean");
    end else begin
      $display("tb_resp_request_parser: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_resp_request_parser: done, errors");
    $finish;
  end
endmodule

>>> filelist.f
src/rrp_pkg.sv
src/rrp_parser.sv
src/rrp_out_queue.sv
src/resp_request_parser.sv
src/rrp_checker.sv
tb/tb_resp_request_parser.sv
